// ===== rtl/rlebd_pkg.sv =====
// package for the byte run-length decompressor
// holds the command type passed from front to back and the default constants
`timescale 1ns / 1ps

package rlebd_pkg;

   localparam int unsigned LANES_DEFAULT       = 4;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned MAX_LANES           = 4;
   localparam logic [7:0]  TAG_RESET           = 8'd48;
   localparam logic [7:0]  RUN_FLAG            = 8'h80;
   localparam logic [7:0]  RUN_BIAS            = 8'd3;
   localparam logic [7:0]  LITERAL_BIAS        = 8'd1;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] len;
      logic       eos;
      logic       err;
   } cmd_type;

endpackage

// ===== rtl/rlebd_front.sv =====
// front end: header parse, control byte classification, command generation
// depends on rlebd_pkg
`timescale 1ns / 1ps

module rlebd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_data,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 stream_start,
   output logic                 push,
   output rlebd_pkg::cmd_type   push_cmd
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_CTRL,
      PH_RUNVAL,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  hdr_tag_ff, hdr_tag_in;
   logic [15:0] hdr_size_ff, hdr_size_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [7:0]  seg_ff, seg_in;
   logic [7:0]  tag_ff, tag_in;

   logic [23:0] full_size;
   logic [7:0]  raw_len;
   logic [23:0] run_rest;
   logic [23:0] lit_rest;

   assign full_size = {in_byte, hdr_size_ff};
   assign raw_len   = ((in_byte & rlebd_pkg::RUN_FLAG) != 8'd0)
                      ? ({1'b0, in_byte[6:0]} + rlebd_pkg::RUN_BIAS)
                      : ({1'b0, in_byte[6:0]} + rlebd_pkg::LITERAL_BIAS);
   assign run_rest  = remaining_ff - {16'd0, seg_ff};
   assign lit_rest  = remaining_ff - 24'd1;
   assign tag_in    = csr_valid ? csr_data : tag_ff;

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      hdr_tag_in   = hdr_tag_ff;
      hdr_size_in  = hdr_size_ff;
      remaining_in = remaining_ff;
      seg_in       = seg_ff;
      push         = 1'b0;
      push_cmd     = '0;
      if (accept) begin
         if (stream_start) begin
            hdr_tag_in   = in_byte;
            hdr_idx_in   = 2'd1;
            remaining_in = '0;
            seg_in       = '0;
            phase_in     = PH_HEADER;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (hdr_idx_ff == 2'd3) begin
                     hdr_idx_in = 2'd0;
                     if (hdr_tag_ff != tag_ff) begin
                        push         = 1'b1;
                        push_cmd.eos = 1'b1;
                        push_cmd.err = 1'b1;
                        phase_in     = PH_DONE;
                     end else if (full_size == 24'd0) begin
                        push         = 1'b1;
                        push_cmd.eos = 1'b1;
                        phase_in     = PH_DONE;
                     end else begin
                        remaining_in = full_size;
                        phase_in     = PH_CTRL;
                     end
                  end else begin
                     if (hdr_idx_ff == 2'd1) begin
                        hdr_size_in[7:0] = in_byte;
                     end else begin
                        hdr_size_in[15:8] = in_byte;
                     end
                     hdr_idx_in = hdr_idx_ff + 2'd1;
                  end
               end
               PH_CTRL: begin
                  seg_in   = (remaining_ff < {16'd0, raw_len}) ? remaining_ff[7:0] : raw_len;
                  phase_in = ((in_byte & rlebd_pkg::RUN_FLAG) != 8'd0) ? PH_RUNVAL
                                                                        : PH_LITERAL;
               end
               PH_RUNVAL: begin
                  push           = 1'b1;
                  push_cmd.value = in_byte;
                  push_cmd.len   = seg_ff;
                  push_cmd.eos   = (run_rest == 24'd0);
                  remaining_in   = run_rest;
                  seg_in         = '0;
                  phase_in       = (run_rest == 24'd0) ? PH_DONE : PH_CTRL;
               end
               PH_LITERAL: begin
                  push           = 1'b1;
                  push_cmd.value = in_byte;
                  push_cmd.len   = 8'd1;
                  push_cmd.eos   = (lit_rest == 24'd0);
                  remaining_in   = lit_rest;
                  seg_in         = seg_ff - 8'd1;
                  if (lit_rest == 24'd0) begin
                     phase_in = PH_DONE;
                  end else if (seg_ff == 8'd1) begin
                     phase_in = PH_CTRL;
                  end
               end
               PH_IDLE, PH_DONE: begin
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_idx_ff   <= '0;
         hdr_tag_ff   <= '0;
         hdr_size_ff  <= '0;
         remaining_ff <= '0;
         seg_ff       <= '0;
         tag_ff       <= rlebd_pkg::TAG_RESET;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         hdr_tag_ff   <= hdr_tag_in;
         hdr_size_ff  <= hdr_size_in;
         remaining_ff <= remaining_in;
         seg_ff       <= seg_in;
         tag_ff       <= tag_in;
      end
   end

endmodule

// ===== rtl/rlebd_queue.sv =====
// command queue between front and back ends
// depends on rlebd_pkg
`timescale 1ns / 1ps

module rlebd_queue #(
   parameter int unsigned DEPTH = rlebd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rlebd_pkg::cmd_type   push_cmd,
   output logic                 full,
   input  logic                 pop,
   output rlebd_pkg::cmd_type   head_cmd,
   output logic                 empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rlebd_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rlebd_back.sv =====
// back end: expands commands into packed result words with an output register
// depends on rlebd_pkg
`timescale 1ns / 1ps

module rlebd_back #(
   parameter int unsigned LANES = rlebd_pkg::LANES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rlebd_pkg::cmd_type   head_cmd,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte0,
   output logic [7:0]           rsp_out_byte1,
   output logic [7:0]           rsp_out_byte2,
   output logic [7:0]           rsp_out_byte3,
   output logic [2:0]           rsp_byte_count,
   output logic                 rsp_end_of_run,
   output logic                 rsp_end_of_stream,
   output logic                 rsp_header_error
);

   localparam int unsigned USED_LANES = (LANES > rlebd_pkg::MAX_LANES) ? rlebd_pkg::MAX_LANES
                                      : ((LANES < 1) ? 1 : LANES);
   localparam logic [7:0] LANES_LEN = 8'(USED_LANES);

   logic       active_ff, active_in;
   logic [7:0] value_ff, value_in;
   logic [7:0] left_ff, left_in;
   logic       eos_ff, eos_in;
   logic       err_ff, err_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff [4];
   logic [7:0] byte_in [4];
   logic [2:0] count_ff, count_in;
   logic       eor_ff, eor_in;
   logic       oeos_ff, oeos_in;
   logic       oerr_ff, oerr_in;

   logic       out_free, emit;
   logic [7:0] src_value, src_left, chunk, rest;
   logic       src_eos, src_err;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = out_free && (active_ff || !empty);
   assign pop       = emit && !active_ff;
   assign src_value = active_ff ? value_ff : head_cmd.value;
   assign src_left  = active_ff ? left_ff : head_cmd.len;
   assign src_eos   = active_ff ? eos_ff : head_cmd.eos;
   assign src_err   = active_ff ? err_ff : head_cmd.err;
   assign chunk     = (src_left > LANES_LEN) ? LANES_LEN : src_left;
   assign rest      = src_left - chunk;

   always_comb begin
      active_in    = active_ff;
      value_in     = value_ff;
      left_in      = left_ff;
      eos_in       = eos_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      eor_in       = eor_ff;
      oeos_in      = oeos_ff;
      oerr_in      = oerr_ff;
      for (int j = 0; j < 4; j++) begin
         byte_in[j] = byte_ff[j];
      end
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         active_in = (rest != 8'd0);
         value_in  = src_value;
         left_in   = rest;
         eos_in    = src_eos;
         err_in    = src_err;
         count_in  = chunk[2:0];
         eor_in    = (rest == 8'd0);
         oeos_in   = (rest == 8'd0) && src_eos;
         oerr_in   = src_err;
         for (int j = 0; j < 4; j++) begin
            byte_in[j] = (8'(j) < chunk) ? src_value : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      left_ff  <= left_in;
      eos_ff   <= eos_in;
      err_ff   <= err_in;
      count_ff <= count_in;
      eor_ff   <= eor_in;
      oeos_ff  <= oeos_in;
      oerr_ff  <= oerr_in;
      for (int j = 0; j < 4; j++) begin
         byte_ff[j] <= byte_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte0     = byte_ff[0];
   assign rsp_out_byte1     = byte_ff[1];
   assign rsp_out_byte2     = byte_ff[2];
   assign rsp_out_byte3     = byte_ff[3];
   assign rsp_byte_count    = count_ff;
   assign rsp_end_of_run    = eor_ff;
   assign rsp_end_of_stream = oeos_ff;
   assign rsp_header_error  = oerr_ff;

endmodule

// ===== rtl/rle_byte_decompressor.sv =====
// top level of the byte run-length decompressor: front end, command queue, back end
// depends on rlebd_pkg, rlebd_front, rlebd_queue, rlebd_back
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_in_byte, req_stream_start
//   rsp_      out        rsp_valid / rsp_stall  rsp_out_byte0..3, rsp_byte_count,
//                                               rsp_end_of_run, rsp_end_of_stream,
//                                               rsp_header_error
//   csr_      in         csr_valid / csr_ready  csr_data (expected tag)
//
// header, control and literal bytes are accepted at the input whenever it does not stall
// a run value byte yields ceil(len / lanes) results, one per cycle from the back end while rsp_stall is low
// the input stalls only while the command queue is full
// synchronous reset clears parse state, queue and output valid; tag resets to 48
// csr_ready is always high
`timescale 1ns / 1ps

module rle_byte_decompressor #(
   parameter int unsigned LANES       = rlebd_pkg::LANES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = rlebd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte0,
   output logic [7:0]  rsp_out_byte1,
   output logic [7:0]  rsp_out_byte2,
   output logic [7:0]  rsp_out_byte3,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_end_of_run,
   output logic        rsp_end_of_stream,
   output logic        rsp_header_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   rlebd_pkg::cmd_type push_cmd, head_cmd;
   logic               push, pop, full, empty, accept;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   rlebd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .stream_start (req_stream_start),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   rlebd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty)
   );

   rlebd_back #(
      .LANES (LANES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte0     (rsp_out_byte0),
      .rsp_out_byte1     (rsp_out_byte1),
      .rsp_out_byte2     (rsp_out_byte2),
      .rsp_out_byte3     (rsp_out_byte3),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_header_error  (rsp_header_error)
   );

endmodule

// ===== test/tb_top.sv =====
// testbench for rle_byte_decompressor: directed streams, then random streams under random idling
// keeps its own decoder of the compressed stream and a script of expected words, and checks every response
// depends on rlebd_pkg and the rle_byte_decompressor rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CLOCK_PERIOD    = 10;
   localparam int unsigned RESET_CYCLES    = 8;
   localparam int unsigned LANE_COUNT      =
      (rlebd_pkg::LANES_DEFAULT > rlebd_pkg::MAX_LANES) ? rlebd_pkg::MAX_LANES :
      (rlebd_pkg::LANES_DEFAULT < 1) ? 1 : rlebd_pkg::LANES_DEFAULT;
   localparam int unsigned RANDOM_ITEMS    = 160;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT     = 5_000_000;
   localparam int unsigned SCRIPT_ROWS     = 27;

   typedef enum logic [2:0] {
      P_IDLE,
      P_HEADER,
      P_CONTROL,
      P_RUN_VALUE,
      P_LITERAL,
      P_DONE
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] count;
      logic       run_end;
      logic       stream_end;
      logic       hdr_err;
   } out_word_type;

   typedef struct packed {
      logic [7:0]   value;
      logic         start;
      logic         typed;
      out_word_type want;
   } script_row_type;

   localparam out_word_type NO_WORD = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_stream_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [7:0] rsp_out_byte3;
   logic [2:0] rsp_byte_count;
   logic       rsp_end_of_run;
   logic       rsp_end_of_stream;
   logic       rsp_header_error;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'd0;

   // decoder state
   parse_phase_type parse_phase = P_IDLE;
   logic [1:0]      hdr_index = 2'd0;
   logic [31:0]     hdr_word = 32'd0;
   logic [23:0]     bytes_owed = 24'd0;
   logic [7:0]      seg_left = 8'd0;
   logic [7:0]      tag_reg = rlebd_pkg::TAG_RESET;

   out_word_type    pending_words[$];
   script_row_type  script [SCRIPT_ROWS];
   int unsigned     fail_count = 0;
   int unsigned     useful_count = 0;
   int unsigned     cycle_count = 0;
   bit              no_gaps = 1'b0;
   bit              hold_off_pending = 1'b0;

   rle_byte_decompressor #(.LANES(LANE_COUNT)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_stream_start  (req_stream_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte0     (rsp_out_byte0),
      .rsp_out_byte1     (rsp_out_byte1),
      .rsp_out_byte2     (rsp_out_byte2),
      .rsp_out_byte3     (rsp_out_byte3),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_header_error  (rsp_header_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic out_word_type pack_word(input logic [7:0] value,
                                              input logic [2:0] count,
                                              input logic run_end, input logic stream_end,
                                              input logic hdr_err);
      out_word_type w;
      w.byte0      = (count > 0) ? value : 8'd0;
      w.byte1      = (count > 1) ? value : 8'd0;
      w.byte2      = (count > 2) ? value : 8'd0;
      w.byte3      = (count > 3) ? value : 8'd0;
      w.count      = count;
      w.run_end    = run_end;
      w.stream_end = stream_end;
      w.hdr_err    = hdr_err;
      return w;
   endfunction

   // advances the decoder by one accepted byte and, when queue_it is set, queues the words it owes
   task automatic decode_byte(input logic [7:0] value, input logic start, input bit queue_it);
      logic [8:0] seg_len;
      logic [7:0] lanes_left;
      logic [2:0] chunk;
      if (start) begin
         hdr_word    = {24'd0, value};
         hdr_index   = 2'd1;
         bytes_owed  = 24'd0;
         seg_left    = 8'd0;
         parse_phase = P_HEADER;
         return;
      end
      case (parse_phase)
         P_HEADER: begin
            hdr_word = hdr_word | (32'(value) << (8 * hdr_index));
            if (hdr_index == 2'd3) begin
               hdr_index = 2'd0;
               if (hdr_word[7:0] != tag_reg) begin
                  if (queue_it) pending_words.push_back(pack_word(8'd0, 3'd0, 1'b1, 1'b1, 1'b1));
                  parse_phase = P_DONE;
               end else begin
                  bytes_owed = hdr_word[31:8];
                  if (bytes_owed == 0) begin
                     if (queue_it)
                        pending_words.push_back(pack_word(8'd0, 3'd0, 1'b1, 1'b1, 1'b0));
                     parse_phase = P_DONE;
                  end else begin
                     parse_phase = P_CONTROL;
                  end
               end
            end else begin
               hdr_index = hdr_index + 2'd1;
            end
         end
         P_CONTROL: begin
            if ((value & rlebd_pkg::RUN_FLAG) != 0) begin
               seg_len     = 9'(value[6:0]) + 9'(rlebd_pkg::RUN_BIAS);
               parse_phase = P_RUN_VALUE;
            end else begin
               seg_len     = 9'(value) + 9'(rlebd_pkg::LITERAL_BIAS);
               parse_phase = P_LITERAL;
            end
            if (24'(seg_len) > bytes_owed) seg_len = bytes_owed[8:0];
            seg_left = seg_len[7:0];
         end
         P_RUN_VALUE: begin
            lanes_left = seg_left;
            bytes_owed = bytes_owed - 24'(seg_left);
            seg_left   = 8'd0;
            while (lanes_left != 0) begin
               chunk      = (lanes_left > LANE_COUNT) ? 3'(LANE_COUNT) : 3'(lanes_left);
               lanes_left = lanes_left - 8'(chunk);
               if (queue_it)
                  pending_words.push_back(pack_word(value, chunk, lanes_left == 0,
                                                    lanes_left == 0 && bytes_owed == 0, 1'b0));
            end
            parse_phase = (bytes_owed == 0) ? P_DONE : P_CONTROL;
         end
         P_LITERAL: begin
            seg_left   = seg_left - 8'd1;
            bytes_owed = bytes_owed - 24'd1;
            if (queue_it)
               pending_words.push_back(pack_word(value, 3'd1, 1'b1, bytes_owed == 0, 1'b0));
            if (bytes_owed == 0)
               parse_phase = P_DONE;
            else if (seg_left == 0)
               parse_phase = P_CONTROL;
         end
         default: ;
      endcase
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input logic [7:0] value, input logic start, input bit queue_it);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= value;
      req_stream_start <= start;
      do @(posedge clock); while (req_stall);
      if (start || (parse_phase != P_IDLE && parse_phase != P_DONE)) useful_count++;
      decode_byte(value, start, queue_it);
   endtask

   task automatic write_tag(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tag_reg = value;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_stream();
      logic [23:0] size;
      logic [7:0]  hdr_tag;
      logic [7:0]  ctrl;
      int unsigned r;
      int unsigned hdr_len;
      int unsigned cap;
      int unsigned steps;
      hdr_tag = ($urandom_range(0, 99) < 85) ? tag_reg : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 8)
         size = 24'd0;
      else if (r < 85)
         size = 24'($urandom_range(1, 40));
      else if (r < 95)
         size = 24'($urandom_range(41, 400));
      else
         size = 24'hFFFFFF ^ 24'($urandom_range(0, 255));
      hdr_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 4;
      cap     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 80;
      send_request(hdr_tag, 1'b1, 1'b1);
      for (int i = 1; i < hdr_len; i++) send_request(size[8 * (i - 1) +: 8], 1'b0, 1'b1);
      steps = 0;
      while ((parse_phase == P_CONTROL || parse_phase == P_RUN_VALUE ||
              parse_phase == P_LITERAL) && steps < cap) begin
         if (parse_phase == P_CONTROL) begin
            if ($urandom_range(0, 99) < 45)
               ctrl = {1'b1, ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                             7'($urandom_range(0, 9))};
            else
               ctrl = {1'b0, ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                             7'($urandom_range(0, 5))};
            send_request(ctrl, 1'b0, 1'b1);
         end else begin
            send_request(8'($urandom), 1'b0, 1'b1);
         end
         steps++;
      end
      if ($urandom_range(0, 99) < 15)
         repeat ($urandom_range(1, 2)) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // response stall pattern, with one long hold-off on request
   initial begin
      int unsigned r;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (r < 40) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      out_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("response with no request pending: byte_count %0d", rsp_byte_count);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            check_field("out_byte0", want.byte0, rsp_out_byte0);
            check_field("out_byte1", want.byte1, rsp_out_byte1);
            check_field("out_byte2", want.byte2, rsp_out_byte2);
            check_field("out_byte3", want.byte3, rsp_out_byte3);
            check_field("byte_count", want.count, rsp_byte_count);
            check_field("end_of_run", want.run_end, rsp_end_of_run);
            check_field("end_of_stream", want.stream_end, rsp_end_of_stream);
            check_field("header_error", want.hdr_err, rsp_header_error);
         end
      end
   end

   initial begin
      int unsigned phase_no;
      logic [7:0]  tag_value;
      script = '{
         '{8'h55, 1'b0, 1'b0, NO_WORD},
         // wrong tag
         '{8'h31, 1'b1, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b1, pack_word(8'h00, 3'd0, 1'b1, 1'b1, 1'b1)},
         '{8'hAA, 1'b0, 1'b0, NO_WORD},
         // seven bytes: run of four, two literals, clipped run
         '{rlebd_pkg::TAG_RESET, 1'b1, 1'b0, NO_WORD},
         '{8'h07, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h81, 1'b0, 1'b0, NO_WORD},
         '{8'hFF, 1'b0, 1'b0, NO_WORD},
         '{8'h01, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b1, pack_word(8'h00, 3'd1, 1'b1, 1'b0, 1'b0)},
         '{8'hFF, 1'b0, 1'b1, pack_word(8'hFF, 3'd1, 1'b1, 1'b0, 1'b0)},
         '{8'hFF, 1'b0, 1'b0, NO_WORD},
         '{8'h80, 1'b0, 1'b1, pack_word(8'h80, 3'd1, 1'b1, 1'b1, 1'b0)},
         // largest size, cut short by a restart
         '{rlebd_pkg::TAG_RESET, 1'b1, 1'b0, NO_WORD},
         '{8'hFF, 1'b0, 1'b0, NO_WORD},
         '{8'hFF, 1'b0, 1'b0, NO_WORD},
         '{8'hFF, 1'b0, 1'b0, NO_WORD},
         '{8'h7F, 1'b0, 1'b0, NO_WORD},
         '{8'h12, 1'b0, 1'b1, pack_word(8'h12, 3'd1, 1'b1, 1'b0, 1'b0)},
         // size zero
         '{rlebd_pkg::TAG_RESET, 1'b1, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b0, NO_WORD},
         '{8'h00, 1'b0, 1'b1, pack_word(8'h00, 3'd0, 1'b1, 1'b1, 1'b0)}
      };
      while (reset !== 1'b0) @(posedge clock);
      foreach (script[i]) begin
         send_request(script[i].value, script[i].start, !script[i].typed);
         if (script[i].typed) pending_words.push_back(script[i].want);
      end
      useful_count = 0;
      phase_no = 0;
      while (useful_count < RANDOM_ITEMS) begin
         settle();
         case (phase_no)
            0:       tag_value = 8'h00;
            1:       tag_value = 8'hFF;
            2:       tag_value = rlebd_pkg::TAG_RESET;
            default: tag_value = 8'($urandom_range(0, 255));
         endcase
         write_tag(tag_value);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase_no == 1) begin
            // long literal stream offered while the receiver holds off
            hold_off_pending = 1'b1;
            while (hold_off_pending) @(posedge clock);
            send_request(tag_reg, 1'b1, 1'b1);
            send_request(8'd24, 1'b0, 1'b1);
            send_request(8'd0, 1'b0, 1'b1);
            send_request(8'd0, 1'b0, 1'b1);
            send_request(8'd23, 1'b0, 1'b1);
            repeat (24) send_request(8'($urandom), 1'b0, 1'b1);
         end
         repeat ($urandom_range(2, 3)) send_stream();
         phase_no++;
      end
      settle();
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rlebd_pkg.sv
rtl/rlebd_front.sv
rtl/rlebd_queue.sv
rtl/rlebd_back.sv
rtl/rle_byte_decompressor.sv
test/tb_top.sv
